// ----- rtl/jsu_pkg.sv -----
// jsu_pkg: shared types and constants of the JSON string unescaper.
// Used by jsu_front, jsu_queue, jsu_back and json_string_unescape.
package jsu_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NO_OPEN = 3'd1,
		ST_BAD_ESC = 3'd2,
		ST_BAD_HEX = 3'd3,
		ST_UNTERM  = 3'd4,
		ST_SPARE   = 3'd5
	} status_t;

	// One accepted byte's worth of output beats: up to three data bytes,
	// then an optional status beat.
	typedef struct packed {
		logic [1:0] n_data;
		logic [7:0] d0;
		logic [7:0] d1;
		logic [7:0] d2;
		logic       has_status;
		status_t    status;
	} cmd_t;

	typedef struct packed {
		logic           full;
		logic           empty;
		logic [QCW-1:0] count;
	} q_stat_t;

endpackage

// ----- rtl/json_string_unescape.sv -----
// json_string_unescape: top level of the streaming JSON string decoder.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
// One raw byte is accepted per cycle while the four-entry command queue has
// room; the front decodes it in that cycle and queues the beats it causes
// (zero to three data bytes, plus a status beat on the end-of-text byte).
// The back sends one beat per cycle from the queue head while out_ready is
// high and holds the beat while it is low, so the first beat of a byte
// appears at the earliest the cycle after it is accepted. Sustained
// input rate is one byte per cycle as long as outputs average one beat per
// input byte; the queue depth absorbs the bursts of a \uXXXX escape.
module json_string_unescape (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	input  logic       in_valid,
	output logic       in_ready,
	output logic [7:0] out_byte,
	output logic       is_status,
	output logic [2:0] status,
	output logic       run_last,
	output logic       out_valid,
	input  logic       out_ready
);
	import jsu_pkg::*;

	cmd_t    wr_cmd, rd_cmd;
	q_stat_t q_stat;
	logic    push, pop;

	jsu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.q_full      (q_stat.full),
		.push        (push),
		.cmd         (wr_cmd)
	);

	jsu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (rd_cmd),
		.stat   (q_stat)
	);

	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (rd_cmd),
		.q_empty   (q_stat.empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.is_status (is_status),
		.status    (status),
		.run_last  (run_last),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_status) |-> run_last)
		else $error("status beat not marked last");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= QCW'(QDEPTH))
		else $error("queue count overflow");

	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == !q_stat.full)
		else $error("ready disagrees with queue room");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (q_stat.count == QCW'($past(q_stat.count) - 1'b1)))
		else $error("pop did not drain queue");

endmodule

// ----- rtl/jsu_front.sv -----
// jsu_front: accepts raw bytes, runs the decode state and builds one command per byte.
// Depends on jsu_pkg.
module jsu_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    in_byte,
	input  logic          end_of_text,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          q_full,
	output logic          push,
	output jsu_pkg::cmd_t cmd
);
	import jsu_pkg::*;

	typedef enum logic [2:0] {
		PH_LEAD = 3'd0,
		PH_STR  = 3'd1,
		PH_ESC  = 3'd2,
		PH_HEX  = 3'd3,
		PH_TAIL = 3'd4,
		PH_HALT = 3'd5
	} phase_t;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;

	phase_t      phase_q, ph_n;
	logic [1:0]  hc_q, hc_n;
	logic [15:0] acc_q, acc_n;
	status_t     err_q, err_n;
	logic [3:0]  hv;
	logic        hv_ok;
	logic        accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		hv    = 4'd0;
		hv_ok = 1'b1;
		if (in_byte inside {[8'h30:8'h39]}) begin
			hv = 4'(in_byte - 8'h30);
		end else if (in_byte inside {[8'h41:8'h46]}) begin
			hv = 4'(in_byte - 8'h41 + 8'd10);
		end else if (in_byte inside {[8'h61:8'h66]}) begin
			hv = 4'(in_byte - 8'h61 + 8'd10);
		end else begin
			hv_ok = 1'b0;
		end
	end

	always_comb begin
		ph_n   = phase_q;
		hc_n   = hc_q;
		acc_n  = acc_q;
		err_n  = err_q;
		cmd    = '0;
		cmd.status = ST_OK;
		case (phase_q)
			PH_LEAD: begin
				if (in_byte > CH_SPACE) begin
					if (in_byte == CH_QUOTE) begin
						ph_n = PH_STR;
					end else begin
						ph_n  = PH_HALT;
						err_n = ST_NO_OPEN;
					end
				end
			end
			PH_STR: begin
				if (in_byte == CH_QUOTE) begin
					ph_n = PH_TAIL;
				end else if (in_byte == CH_BSL) begin
					ph_n = PH_ESC;
				end else begin
					cmd.n_data = 2'd1;
					cmd.d0     = in_byte;
				end
			end
			PH_ESC: begin
				ph_n       = PH_STR;
				cmd.n_data = 2'd1;
				case (in_byte)
					CH_QUOTE, CH_BSL, CH_SLASH: cmd.d0 = in_byte;
					CH_B: cmd.d0 = 8'h08;
					CH_F: cmd.d0 = 8'h0C;
					CH_N: cmd.d0 = 8'h0A;
					CH_R: cmd.d0 = 8'h0D;
					CH_T: cmd.d0 = 8'h09;
					CH_U: begin
						cmd.n_data = 2'd0;
						ph_n       = PH_HEX;
						hc_n       = 2'd0;
						acc_n      = 16'd0;
					end
					default: begin
						cmd.n_data = 2'd0;
						ph_n       = PH_HALT;
						err_n      = ST_BAD_ESC;
					end
				endcase
			end
			PH_HEX: begin
				if (!hv_ok) begin
					ph_n  = PH_HALT;
					err_n = ST_BAD_HEX;
				end else begin
					acc_n = {acc_q[11:0], hv};
					if (hc_q == 2'd3) begin
						hc_n = 2'd0;
						ph_n = PH_STR;
						if (acc_n < 16'h0080) begin
							cmd.n_data = 2'd1;
							cmd.d0     = acc_n[7:0];
						end else if (acc_n < 16'h0800) begin
							cmd.n_data = 2'd2;
							cmd.d0     = {3'b110, acc_n[10:6]};
							cmd.d1     = {2'b10, acc_n[5:0]};
						end else begin
							cmd.n_data = 2'd3;
							cmd.d0     = {4'b1110, acc_n[15:12]};
							cmd.d1     = {2'b10, acc_n[11:6]};
							cmd.d2     = {2'b10, acc_n[5:0]};
						end
					end else begin
						hc_n = hc_q + 2'd1;
					end
				end
			end
			PH_TAIL: begin
				if (in_byte > CH_SPACE) begin
					ph_n  = PH_HALT;
					err_n = ST_SPARE;
				end
			end
			default: ;
		endcase

		if (end_of_text) begin
			cmd.has_status = 1'b1;
			cmd.status     = err_n;
			if (err_n == ST_OK) begin
				case (ph_n)
					PH_LEAD: cmd.status = ST_NO_OPEN;
					PH_STR:  cmd.status = ST_UNTERM;
					PH_ESC:  cmd.status = ST_BAD_ESC;
					PH_HEX:  cmd.status = ST_BAD_HEX;
					default: cmd.status = ST_OK;
				endcase
			end
			ph_n  = PH_LEAD;
			hc_n  = 2'd0;
			acc_n = 16'd0;
			err_n = ST_OK;
		end
	end

	assign push = accept && ((cmd.n_data != 2'd0) || cmd.has_status);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			hc_q    <= 2'd0;
			acc_q   <= 16'd0;
			err_q   <= ST_OK;
		end else if (accept) begin
			phase_q <= ph_n;
			hc_q    <= hc_n;
			acc_q   <= acc_n;
			err_q   <= err_n;
		end
	end

endmodule

// ----- rtl/jsu_queue.sv -----
// jsu_queue: short command FIFO between front and back.
// Depends on jsu_pkg.
module jsu_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jsu_pkg::cmd_t    wr_cmd,
	input  logic             pop,
	output jsu_pkg::cmd_t    rd_cmd,
	output jsu_pkg::q_stat_t stat
);
	import jsu_pkg::*;

	cmd_t           mem_q [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QCW-1:0] cnt_q;
	logic           do_push, do_pop;

	assign stat.full  = (cnt_q == QCW'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign stat.count = cnt_q;
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_cmd     = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= QAW'(wp_q + 1'b1);
			end
			if (do_pop) begin
				rp_q <= QAW'(rp_q + 1'b1);
			end
			cnt_q <= QCW'(cnt_q + QCW'(do_push) - QCW'(do_pop));
		end
	end

endmodule

// ----- rtl/jsu_back.sv -----
// jsu_back: walks the head command and sends its beats one per cycle while out_ready is high.
// Depends on jsu_pkg.
module jsu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  jsu_pkg::cmd_t cmd,
	input  logic          q_empty,
	output logic          pop,
	output logic [7:0]    out_byte,
	output logic          is_status,
	output logic [2:0]    status,
	output logic          run_last,
	output logic          out_valid,
	input  logic          out_ready
);
	import jsu_pkg::*;

	logic [1:0] idx_q;
	logic [2:0] total;
	logic       beat;

	assign out_valid = !q_empty;
	assign total     = {1'b0, cmd.n_data} + {2'b00, cmd.has_status};
	assign run_last  = ({1'b0, idx_q} + 3'd1) == total;
	assign beat      = out_valid && out_ready;
	assign pop       = beat && run_last;

	always_comb begin
		out_byte  = 8'h00;
		is_status = 1'b0;
		status    = ST_OK;
		if (idx_q < cmd.n_data) begin
			case (idx_q)
				2'd0:    out_byte = cmd.d0;
				2'd1:    out_byte = cmd.d1;
				default: out_byte = cmd.d2;
			endcase
		end else begin
			is_status = 1'b1;
			status    = cmd.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (pop) begin
			idx_q <= 2'd0;
		end else if (beat) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

// ----- sim/tb.sv -----
// tb: self-checking testbench for json_string_unescape, the streaming JSON string decoder.
// Predicts every output beat from the accepted input bytes and compares them field by field.
// Depends on jsu_pkg and json_string_unescape.
`timescale 1ns / 1ps

module tb;
	import jsu_pkg::*;

	localparam logic [7:0] SP     = 8'h20;
	localparam logic [7:0] QUOTE  = 8'h22;
	localparam logic [7:0] SLASH  = 8'h2F;
	localparam logic [7:0] BSLASH = 8'h5C;
	localparam logic [7:0] ESC_B  = 8'h62;
	localparam logic [7:0] ESC_F  = 8'h66;
	localparam logic [7:0] ESC_N  = 8'h6E;
	localparam logic [7:0] ESC_R  = 8'h72;
	localparam logic [7:0] ESC_T  = 8'h74;
	localparam logic [7:0] ESC_U  = 8'h75;
	localparam int QUIET_LIMIT    = 2000;
	localparam int HOLD_CYCLES    = 120;
	localparam int RANDOM_BYTES   = 205;

	typedef enum logic [2:0] {
		DEC_LEAD, DEC_STR, DEC_ESC, DEC_HEX, DEC_TAIL, DEC_HALT
	} dec_phase_t;

	typedef struct packed {
		logic [7:0] b;
		logic       eot;
	} text_byte_t;

	typedef struct packed {
		logic [7:0] b;
		logic       flag;
		status_t    st;
		logic       last;
	} beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       end_of_text = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] out_byte;
	logic       is_status;
	logic [2:0] status;
	logic       run_last;
	logic       out_valid;
	logic       out_ready = 1'b0;

	json_string_unescape dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_byte(in_byte),
		.end_of_text(end_of_text),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_byte(out_byte),
		.is_status(is_status),
		.status(status),
		.run_last(run_last),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	text_byte_t pending[$];
	logic [7:0] text_bytes[$];
	beat_t      want_beats[$];

	dec_phase_t dec_phase = DEC_LEAD;
	logic [1:0] dec_hex_n = 2'd0;
	logic [15:0] dec_code = 16'h0000;
	status_t    dec_err = ST_OK;
	beat_t      held;
	bit         have_held = 1'b0;

	int errors = 0;
	int texts = 0;
	int bytes_in = 0;
	int beats_out = 0;
	int status_seen[6] = '{0, 0, 0, 0, 0, 0};

	int send_wait, send_run, recv_wait, recv_run, rw, hold_left, quiet;
	bit hold_done;
	text_byte_t nxt;
	beat_t want;

	function automatic logic [4:0] hex_nibble(logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39)
			return {1'b0, c[3:0]};
		if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
			return {1'b0, c[3:0] + 4'd9};
		return 5'd16;
	endfunction

	// keeps the newest beat back so the last one of a byte can be marked
	function automatic void add_beat(logic [7:0] b, logic flag, status_t st);
		if (have_held)
			want_beats.push_back(held);
		held.b = b;
		held.flag = flag;
		held.st = st;
		held.last = 1'b0;
		have_held = 1'b1;
	endfunction

	function automatic void decode_byte(logic [7:0] c, logic eot);
		logic [4:0] nib;
		status_t fin;
		have_held = 1'b0;
		case (dec_phase)
		DEC_LEAD: begin
			if (c > SP) begin
				if (c == QUOTE) begin
					dec_phase = DEC_STR;
				end else begin
					dec_err = ST_NO_OPEN;
					dec_phase = DEC_HALT;
				end
			end
		end
		DEC_STR: begin
			if (c == QUOTE)
				dec_phase = DEC_TAIL;
			else if (c == BSLASH)
				dec_phase = DEC_ESC;
			else
				add_beat(c, 1'b0, ST_OK);
		end
		DEC_ESC: begin
			dec_phase = DEC_STR;
			case (c)
			QUOTE, BSLASH, SLASH: add_beat(c, 1'b0, ST_OK);
			ESC_B: add_beat(8'h08, 1'b0, ST_OK);
			ESC_F: add_beat(8'h0C, 1'b0, ST_OK);
			ESC_N: add_beat(8'h0A, 1'b0, ST_OK);
			ESC_R: add_beat(8'h0D, 1'b0, ST_OK);
			ESC_T: add_beat(8'h09, 1'b0, ST_OK);
			ESC_U: begin
				dec_phase = DEC_HEX;
				dec_hex_n = 2'd0;
				dec_code = 16'h0000;
			end
			default: begin
				dec_err = ST_BAD_ESC;
				dec_phase = DEC_HALT;
			end
			endcase
		end
		DEC_HEX: begin
			nib = hex_nibble(c);
			if (nib[4]) begin
				dec_err = ST_BAD_HEX;
				dec_phase = DEC_HALT;
			end else begin
				dec_code = {dec_code[11:0], nib[3:0]};
				if (dec_hex_n == 2'd3) begin
					if (dec_code < 16'h0080) begin
						add_beat(dec_code[7:0], 1'b0, ST_OK);
					end else if (dec_code < 16'h0800) begin
						add_beat({3'b110, dec_code[10:6]}, 1'b0, ST_OK);
						add_beat({2'b10, dec_code[5:0]}, 1'b0, ST_OK);
					end else begin
						add_beat({4'b1110, dec_code[15:12]}, 1'b0, ST_OK);
						add_beat({2'b10, dec_code[11:6]}, 1'b0, ST_OK);
						add_beat({2'b10, dec_code[5:0]}, 1'b0, ST_OK);
					end
					dec_hex_n = 2'd0;
					dec_phase = DEC_STR;
				end else begin
					dec_hex_n = dec_hex_n + 2'd1;
				end
			end
		end
		DEC_TAIL: begin
			if (c > SP) begin
				dec_err = ST_SPARE;
				dec_phase = DEC_HALT;
			end
		end
		default: ;
		endcase
		if (eot) begin
			fin = dec_err;
			if (fin == ST_OK) begin
				case (dec_phase)
				DEC_LEAD: fin = ST_NO_OPEN;
				DEC_STR:  fin = ST_UNTERM;
				DEC_ESC:  fin = ST_BAD_ESC;
				DEC_HEX:  fin = ST_BAD_HEX;
				default:  fin = ST_OK;
				endcase
			end
			add_beat(8'h00, 1'b1, fin);
			dec_phase = DEC_LEAD;
			dec_hex_n = 2'd0;
			dec_code = 16'h0000;
			dec_err = ST_OK;
		end
		if (have_held) begin
			held.last = 1'b1;
			want_beats.push_back(held);
		end
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
		if (n < 4'd10)
			return 8'h30 + n;
		return (upper ? 8'h41 : 8'h61) + n - 8'd10;
	endfunction

	function automatic logic [7:0] esc_letter(int k);
		case (k)
		0: return QUOTE;
		1: return BSLASH;
		2: return SLASH;
		3: return ESC_B;
		4: return ESC_F;
		5: return ESC_N;
		6: return ESC_R;
		default: return ESC_T;
		endcase
	endfunction

	function automatic logic [7:0] blank();
		case ($urandom_range(0, 5))
		0: return 8'h09;
		1: return 8'h0A;
		2: return 8'h0D;
		3: return 8'h00;
		4: return SP;
		default: return 8'($urandom_range(0, 32));
		endcase
	endfunction

	task automatic put(logic [7:0] b);
		text_bytes.push_back(b);
	endtask

	task automatic put_str(string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endtask

	task automatic send_text();
		text_byte_t t;
		for (int i = 0; i < text_bytes.size(); i++) begin
			t.b = text_bytes[i];
			t.eot = (i == text_bytes.size() - 1);
			pending.push_back(t);
		end
		text_bytes.delete();
		texts++;
	endtask

	task automatic add_wellformed();
		int n;
		logic [15:0] cp;
		logic [7:0] c;
		repeat ($urandom_range(0, 2)) put(blank());
		put(QUOTE);
		n = $urandom_range(0, 6);
		repeat (n) begin
			case ($urandom_range(0, 3))
			0, 1: begin
				do c = 8'($urandom_range(0, 255)); while (c == QUOTE || c == BSLASH);
				put(c);
			end
			2: begin
				put(BSLASH);
				put(esc_letter($urandom_range(0, 7)));
			end
			default: begin
				put(BSLASH);
				put(ESC_U);
				case ($urandom_range(0, 3))
				0: cp = 16'($urandom_range(0, 'h7F));
				1: cp = 16'($urandom_range('h80, 'h7FF));
				2: cp = 16'($urandom_range('h800, 'hFFFF));
				default: cp = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				endcase
				for (int i = 3; i >= 0; i--)
					put(hex_char(cp[i*4 +: 4], 1'($urandom_range(0, 1))));
			end
			endcase
		end
		put(QUOTE);
		repeat ($urandom_range(0, 2)) put(blank());
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= 8'h00;
			end_of_text <= 1'b0;
			send_wait <= 0;
			send_run <= 0;
		end else begin
			if (in_valid && in_ready) begin
				decode_byte(in_byte, end_of_text);
				bytes_in <= bytes_in + 1;
			end
			if (!in_valid || in_ready) begin
				if (send_wait != 0) begin
					in_valid <= 1'b0;
					send_wait <= send_wait - 1;
				end else if (pending.size() != 0) begin
					nxt = pending.pop_front();
					in_valid <= 1'b1;
					in_byte <= nxt.b;
					end_of_text <= nxt.eot;
					if (send_run != 0) begin
						send_wait <= 0;
						send_run <= send_run - 1;
					end else begin
						send_wait <= $urandom_range(0, 9);
						if ($urandom_range(0, 15) == 0)
							send_run <= $urandom_range(10, 30);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// one long receiver stall so the queue fills and input backs up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && bytes_in >= 60) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_wait <= 0;
			recv_run <= 0;
		end else begin
			rw = recv_wait;
			if (out_valid && out_ready) begin
				beats_out <= beats_out + 1;
				if (want_beats.size() == 0) begin
					$error("unexpected beat: out_byte %0h is_status %0b status %0d",
						out_byte, is_status, status);
					errors++;
				end else begin
					want = want_beats.pop_front();
					if (out_byte !== want.b) begin
						$error("out_byte: expected %0h, got %0h", want.b, out_byte);
						errors++;
					end
					if (is_status !== want.flag) begin
						$error("is_status: expected %0b, got %0b", want.flag, is_status);
						errors++;
					end
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						errors++;
					end
					if (run_last !== want.last) begin
						$error("run_last: expected %0b, got %0b", want.last, run_last);
						errors++;
					end
					if (want.flag)
						status_seen[want.st]++;
				end
				if (recv_run != 0) begin
					rw = 0;
					recv_run <= recv_run - 1;
				end else begin
					rw = $urandom_range(0, 9);
					if ($urandom_range(0, 15) == 0)
						recv_run <= $urandom_range(10, 30);
				end
			end else if (rw != 0 && hold_left == 0) begin
				rw = rw - 1;
			end
			recv_wait <= rw;
			out_ready <= (rw == 0) && (hold_left == 0);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("tb: watchdog expired, %0d beats outstanding", want_beats.size());
			$display("tb: done, errors");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		int mode;
		int k;

		put(8'h00);
		put(SP);
		send_text();
		put(QUOTE);
		put(8'hFF);
		put_str("\\u0800");
		send_text();
		put_str("\"\\");
		send_text();
		put_str("\"\\uf");
		send_text();
		put_str("x\"");
		send_text();
		put_str("\"\"z");
		send_text();
		put_str("\"\\qa");
		send_text();

		while (pending.size() < RANDOM_BYTES + 25) begin
			add_wellformed();
			mode = $urandom_range(0, 9);
			case (mode)
			7: begin
				k = $urandom_range(1, text_bytes.size());
				while (text_bytes.size() > k)
					text_bytes.delete(text_bytes.size() - 1);
			end
			8: begin
				if ($urandom_range(0, 1))
					text_bytes[$urandom_range(0, text_bytes.size() - 1)] =
						8'($urandom_range(0, 255));
				else
					put(8'($urandom_range(8'h21, 8'hFF)));
			end
			9: begin
				text_bytes.delete();
				repeat ($urandom_range(1, 5)) put(8'($urandom_range(0, 255)));
			end
			default: ;
			endcase
			send_text();
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (pending.size() != 0 || in_valid) @(posedge clk);
		while (want_beats.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("tb: %0d texts, %0d bytes in, %0d beats out", texts, bytes_in, beats_out);
		$display("tb: endings ok %0d, no quote %0d, bad escape %0d, bad hex %0d,",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		$display("tb: open %0d, spare %0d", status_seen[4], status_seen[5]);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

// ----- json_string_unescape.f -----
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape.sv
sim/tb.sv
